### src/euler_to_quaternion_unit_defines.svh
`ifndef EULER_TO_QUATERNION_UNIT_DEFINES_SVH
`define EULER_TO_QUATERNION_UNIT_DEFINES_SVH

// A condition implies an expression in the same cycle.
`define E2Q_ASSERT_IMPLY(name, clk, rst, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("e2q check failed: same-cycle implication");

// A condition implies an expression in the following cycle.
`define E2Q_ASSERT_NEXT(name, clk, rst, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("e2q check failed: next-cycle implication");

`endif

### src/e2q_pkg.sv
package e2q_pkg;

  // Field widths.
  localparam int ANGLE_BITS     = 16;
  localparam int COMPONENT_BITS = 16;

  // Angle lanes, one per Euler angle.
  localparam int LANES      = 3;
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  // Rotation engine: the half-angle phase is 32 bits per turn.
  localparam int CORDIC_STEPS = 28;
  localparam int PH_SHIFT     = 31 - ANGLE_BITS;
  localparam int PH_W         = 34;
  localparam int XY_W         = 33;
  localparam int TRIG_W       = 32;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN  = XY_W'(652032874);
  localparam logic signed [PH_W-1:0] QUARTER_TURN = PH_W'(64'd1 << 30);
  localparam logic signed [PH_W-1:0] HALF_TURN    = PH_W'(64'd1 << 31);

  localparam logic signed [PH_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
    34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
    34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
    34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
    34'sd652, 34'sd326, 34'sd163, 34'sd81,
    34'sd41, 34'sd20, 34'sd10, 34'sd5
  };

  // Product arithmetic.
  localparam int PROD_W     = 64;
  localparam int PAIR_SHIFT = 30;
  localparam int SUM_W      = PROD_W + 1;
  localparam int OUT_SHIFT  = 61 - COMPONENT_BITS;

  // Saturation limits of a quaternion component.
  localparam logic signed [COMPONENT_BITS-1:0] COMP_MAX =
    COMPONENT_BITS'((64'sd1 <<< (COMPONENT_BITS - 1)) - 64'sd1);
  localparam logic signed [COMPONENT_BITS-1:0] COMP_MIN =
    COMPONENT_BITS'(-(64'sd1 <<< (COMPONENT_BITS - 1)));

  // Pipeline depth of each part and of the whole unit.
  localparam int CORDIC_LATENCY = CORDIC_STEPS + 2;
  localparam int QUAT_LATENCY   = 5;
  localparam int PIPE_LATENCY   = CORDIC_LATENCY + QUAT_LATENCY;

endpackage

### src/euler_to_quaternion_unit.sv
// Channel   Ports                                   Handshake
// request   roll_angle, pitch_angle, yaw_angle      start, busy
// result    quat_w, quat_x, quat_y, quat_z          done (one-cycle strobe)
//
// A request is taken on any cycle with start high and busy low; busy is high
// only while rst is held. Every request gives exactly one result, which passes
// through the rotation engine (one register per rotation step plus the phase
// fold and the sign fix) and then the multiply and round stages. Reset is
// synchronous and clears the valid bits; the datapath never stalls.
`include "euler_to_quaternion_unit_defines.svh"

module euler_to_quaternion_unit import e2q_pkg::*; (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [ANGLE_BITS-1:0]            roll_angle,
  input  logic [ANGLE_BITS-1:0]            pitch_angle,
  input  logic [ANGLE_BITS-1:0]            yaw_angle,
  output logic                             done,
  output logic signed [COMPONENT_BITS-1:0] quat_w,
  output logic signed [COMPONENT_BITS-1:0] quat_x,
  output logic signed [COMPONENT_BITS-1:0] quat_y,
  output logic signed [COMPONENT_BITS-1:0] quat_z
);

  logic                     req;
  logic [ANGLE_BITS-1:0]    angle    [LANES];
  logic                     trig_valid;
  logic signed [TRIG_W-1:0] cos_half [LANES];
  logic signed [TRIG_W-1:0] sin_half [LANES];
  logic                     zero_req;
  logic                     identity_out;

  // Requests are refused only during reset.
  assign busy = rst;
  assign req  = start && !busy;

  assign angle[LANE_ROLL]  = roll_angle;
  assign angle[LANE_PITCH] = pitch_angle;
  assign angle[LANE_YAW]   = yaw_angle;

  // Half-angle cosine and sine of all three angles.
  e2q_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req),
    .angle     (angle),
    .out_valid (trig_valid),
    .cos_half  (cos_half),
    .sin_half  (sin_half)
  );

  // Triple products, sums and saturation.
  e2q_quat u_quat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trig_valid),
    .cos_half  (cos_half),
    .sin_half  (sin_half),
    .out_valid (done),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z)
  );

  // A request with all angles zero, and the identity rotation on the outputs.
  assign zero_req     = req && roll_angle == '0 && pitch_angle == '0 && yaw_angle == '0;
  assign identity_out = quat_w == COMP_MAX && quat_x == '0 && quat_y == '0 && quat_z == '0;

  // Each accepted request leaves exactly one result after the full latency.
  `E2Q_ASSERT_IMPLY(a_done_latency, clk, rst, 1'b1, done == $past(req, PIPE_LATENCY))

  // A reset cycle leaves no result strobe behind it.
  `E2Q_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !done)

  // Zero angles give the identity rotation, with w saturated at plus one.
  `E2Q_ASSERT_IMPLY(a_zero_identity, clk, rst, $past(zero_req, PIPE_LATENCY), identity_out)

endmodule

### src/e2q_cordic.sv
module e2q_cordic import e2q_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [ANGLE_BITS-1:0]    angle [LANES],
  output logic                     out_valid,
  output logic signed [TRIG_W-1:0] cos_half [LANES],
  output logic signed [TRIG_W-1:0] sin_half [LANES]
);

  logic signed [XY_W-1:0] xs   [LANES][CORDIC_STEPS+1];
  logic signed [XY_W-1:0] ys   [LANES][CORDIC_STEPS+1];
  logic signed [PH_W-1:0] zs   [LANES][CORDIC_STEPS+1];
  logic                   flip [LANES][CORDIC_STEPS+1];
  logic                   vld  [CORDIC_STEPS+1];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [PH_W-1:0] ph;

    // Half angle as a phase; above a quarter turn, fold by a half turn.
    assign ph = signed'({{(PH_W - ANGLE_BITS - PH_SHIFT){1'b0}}, angle[l],
                         {PH_SHIFT{1'b0}}});

    always_ff @(posedge clk) begin
      xs[l][0] <= CORDIC_GAIN;
      ys[l][0] <= '0;
      if (ph > QUARTER_TURN) begin
        zs[l][0]   <= ph - HALF_TURN;
        flip[l][0] <= 1'b1;
      end else begin
        zs[l][0]   <= ph;
        flip[l][0] <= 1'b0;
      end
    end

    // One rotation step per register stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;

      assign dx = ys[l][i] >>> i;
      assign dy = xs[l][i] >>> i;

      always_ff @(posedge clk) begin
        flip[l][i+1] <= flip[l][i];
        if (!zs[l][i][PH_W-1]) begin
          xs[l][i+1] <= xs[l][i] - dx;
          ys[l][i+1] <= ys[l][i] + dy;
          zs[l][i+1] <= zs[l][i] - ATAN_TURNS[i];
        end else begin
          xs[l][i+1] <= xs[l][i] + dx;
          ys[l][i+1] <= ys[l][i] - dy;
          zs[l][i+1] <= zs[l][i] + ATAN_TURNS[i];
        end
      end
    end

    // Undo the fold by negating both results.
    always_ff @(posedge clk) begin
      if (flip[l][CORDIC_STEPS]) begin
        cos_half[l] <= TRIG_W'(-xs[l][CORDIC_STEPS]);
        sin_half[l] <= TRIG_W'(-ys[l][CORDIC_STEPS]);
      end else begin
        cos_half[l] <= TRIG_W'(xs[l][CORDIC_STEPS]);
        sin_half[l] <= TRIG_W'(ys[l][CORDIC_STEPS]);
      end
    end
  end

  // Valid bits travel alongside the stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
        vld[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        vld[i+1] <= vld[i];
      end
      out_valid <= vld[CORDIC_STEPS];
    end
  end

endmodule

### src/e2q_quat.sv
module e2q_quat import e2q_pkg::*; (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic signed [TRIG_W-1:0]         cos_half [LANES],
  input  logic signed [TRIG_W-1:0]         sin_half [LANES],
  output logic                             out_valid,
  output logic signed [COMPONENT_BITS-1:0] quat_w,
  output logic signed [COMPONENT_BITS-1:0] quat_x,
  output logic signed [COMPONENT_BITS-1:0] quat_y,
  output logic signed [COMPONENT_BITS-1:0] quat_z
);

  localparam int RND_W = SUM_W + 1;
  localparam logic signed [PROD_W-1:0] PAIR_RND = PROD_W'(1) << (PAIR_SHIFT - 1);
  localparam logic signed [RND_W-1:0]  OUT_RND  = RND_W'(1) << (OUT_SHIFT - 1);

  // Round a Q60 sum half up to the output fraction and saturate.
  function automatic logic signed [COMPONENT_BITS-1:0] to_component(
    input logic signed [SUM_W-1:0] s
  );
    logic signed [RND_W-1:0] r;
    r = RND_W'(s) + OUT_RND;
    r = r >>> OUT_SHIFT;
    priority if (r > RND_W'(COMP_MAX)) begin
      return COMP_MAX;
    end else if (r < RND_W'(COMP_MIN)) begin
      return COMP_MIN;
    end else begin
      return COMPONENT_BITS'(r);
    end
  endfunction

  logic [QUAT_LATENCY-2:0] vld;

  // Stage 1: roll-pitch pair products.
  logic signed [PROD_W-1:0] p_cc, p_ss, p_sc, p_cs;
  logic signed [TRIG_W-1:0] cy1, sy1;

  always_ff @(posedge clk) begin
    p_cc <= cos_half[LANE_ROLL] * cos_half[LANE_PITCH];
    p_ss <= sin_half[LANE_ROLL] * sin_half[LANE_PITCH];
    p_sc <= sin_half[LANE_ROLL] * cos_half[LANE_PITCH];
    p_cs <= cos_half[LANE_ROLL] * sin_half[LANE_PITCH];
    cy1  <= cos_half[LANE_YAW];
    sy1  <= sin_half[LANE_YAW];
  end

  // Stage 2: round the pair products back to Q2.30.
  logic signed [TRIG_W-1:0] ab_cc, ab_ss, ab_sc, ab_cs;
  logic signed [TRIG_W-1:0] cy2, sy2;

  always_ff @(posedge clk) begin
    ab_cc <= TRIG_W'((p_cc + PAIR_RND) >>> PAIR_SHIFT);
    ab_ss <= TRIG_W'((p_ss + PAIR_RND) >>> PAIR_SHIFT);
    ab_sc <= TRIG_W'((p_sc + PAIR_RND) >>> PAIR_SHIFT);
    ab_cs <= TRIG_W'((p_cs + PAIR_RND) >>> PAIR_SHIFT);
    cy2   <= cy1;
    sy2   <= sy1;
  end

  // Stage 3: multiply by the yaw factor.
  logic signed [PROD_W-1:0] t_w0, t_w1, t_x0, t_x1, t_y0, t_y1, t_z0, t_z1;

  always_ff @(posedge clk) begin
    t_w0 <= ab_cc * cy2;
    t_w1 <= ab_ss * sy2;
    t_x0 <= ab_sc * cy2;
    t_x1 <= ab_cs * sy2;
    t_y0 <= ab_cs * cy2;
    t_y1 <= ab_sc * sy2;
    t_z0 <= ab_cc * sy2;
    t_z1 <= ab_ss * cy2;
  end

  // Stage 4: exact sums or differences of the two terms of each component.
  logic signed [SUM_W-1:0] s_w, s_x, s_y, s_z;

  always_ff @(posedge clk) begin
    s_w <= SUM_W'(t_w0) + SUM_W'(t_w1);
    s_x <= SUM_W'(t_x0) - SUM_W'(t_x1);
    s_y <= SUM_W'(t_y0) + SUM_W'(t_y1);
    s_z <= SUM_W'(t_z0) - SUM_W'(t_z1);
  end

  // Stage 5: rounding and saturation into the result registers.
  always_ff @(posedge clk) begin
    quat_w <= to_component(s_w);
    quat_x <= to_component(s_x);
    quat_y <= to_component(s_y);
    quat_z <= to_component(s_z);
  end

  // Valid bits for the five stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[QUAT_LATENCY-3:0], in_valid};
      out_valid <= vld[QUAT_LATENCY-2];
    end
  end

endmodule

### bench/tb_euler_to_quaternion_unit.sv
`timescale 1ns / 1ps

module tb_euler_to_quaternion_unit;
  import e2q_pkg::*;

  localparam int     CYCLE_LIMIT   = 200000;
  localparam int     ROT_STEPS     = 28;
  localparam longint ROT_GAIN_Q30  = 64'sd652032874;
  localparam longint PHASE_QUARTER = 64'sd1 <<< 30;
  localparam longint PHASE_HALF    = 64'sd1 <<< 31;
  localparam int     ROUND_SHIFT   = 61 - COMPONENT_BITS;
  localparam longint COMP_HI       = (64'sd1 <<< (COMPONENT_BITS - 1)) - 64'sd1;
  localparam longint COMP_LO       = -(64'sd1 <<< (COMPONENT_BITS - 1));

  // Arctangent of 2^-i, in units of 2^32 per turn.
  localparam longint ARCTAN_PHASE [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  typedef struct {
    logic signed [COMPONENT_BITS-1:0] w;
    logic signed [COMPONENT_BITS-1:0] x;
    logic signed [COMPONENT_BITS-1:0] y;
    logic signed [COMPONENT_BITS-1:0] z;
  } quat_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic [ANGLE_BITS-1:0]            roll_angle = '0;
  logic [ANGLE_BITS-1:0]            pitch_angle = '0;
  logic [ANGLE_BITS-1:0]            yaw_angle = '0;
  logic                             busy;
  logic                             done;
  logic signed [COMPONENT_BITS-1:0] quat_w;
  logic signed [COMPONENT_BITS-1:0] quat_x;
  logic signed [COMPONENT_BITS-1:0] quat_y;
  logic signed [COMPONENT_BITS-1:0] quat_z;

  quat_t pending_quats[$];
  int    requests_sent = 0;
  int    results_seen = 0;
  int    error_count = 0;
  int    cycle_count = 0;

  euler_to_quaternion_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle),
    .done        (done),
    .quat_w      (quat_w),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cosine and sine (Q2.30) of half a binary angle, by a fixed rotation sequence.
  function automatic void half_angle_trig(input logic [ANGLE_BITS-1:0] angle,
                                          output longint cos_q30,
                                          output longint sin_q30);
    longint phase;
    longint xv;
    longint yv;
    longint dx;
    longint dy;
    bit     flip;
    phase = 0;
    phase[ANGLE_BITS-1:0] = angle;
    phase = phase <<< (31 - ANGLE_BITS);
    flip = 1'b0;
    xv = ROT_GAIN_Q30;
    yv = 0;
    // Fold phases past a quarter turn back and fix the sign afterwards.
    if (phase > PHASE_QUARTER) begin
      phase -= PHASE_HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (phase >= 0) begin
        xv -= dx;
        yv += dy;
        phase -= ARCTAN_PHASE[i];
      end else begin
        xv += dx;
        yv -= dy;
        phase += ARCTAN_PHASE[i];
      end
    end
    if (flip) begin
      xv = -xv;
      yv = -yv;
    end
    cos_q30 = xv;
    sin_q30 = yv;
  endfunction

  // Product of three Q2.30 factors in Q60; the first pair is rounded to Q30.
  function automatic longint triple_q60(input longint a, input longint b, input longint c);
    longint ab;
    ab = (a * b + (64'sd1 <<< 29)) >>> 30;
    return ab * c;
  endfunction

  // Round a Q60 sum half up to the component width and saturate.
  function automatic logic signed [COMPONENT_BITS-1:0] round_component(input longint q60);
    longint v;
    v = (q60 + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (v > COMP_HI) v = COMP_HI;
    if (v < COMP_LO) v = COMP_LO;
    return v[COMPONENT_BITS-1:0];
  endfunction

  function automatic quat_t predict_quaternion(input logic [ANGLE_BITS-1:0] roll,
                                               input logic [ANGLE_BITS-1:0] pitch,
                                               input logic [ANGLE_BITS-1:0] yaw);
    longint cr, sr, cp, sp, cy, sy;
    quat_t  q;
    half_angle_trig(roll, cr, sr);
    half_angle_trig(pitch, cp, sp);
    half_angle_trig(yaw, cy, sy);
    q.w = round_component(triple_q60(cr, cp, cy) + triple_q60(sr, sp, sy));
    q.x = round_component(triple_q60(sr, cp, cy) - triple_q60(cr, sp, sy));
    q.y = round_component(triple_q60(cr, sp, cy) + triple_q60(sr, cp, sy));
    q.z = round_component(triple_q60(cr, cp, sy) - triple_q60(sr, sp, cy));
    return q;
  endfunction

  function automatic void check_component(input string label,
                                          input logic signed [COMPONENT_BITS-1:0] want,
                                          input logic signed [COMPONENT_BITS-1:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= 10)
        $display("[%0t] mismatch on quat_%s: expected %0d, got %0d", $realtime, label,
                 want, got);
    end
  endfunction

  // Compare every result strobe with the oldest outstanding request.
  always @(posedge clk) begin
    quat_t want;
    if (!rst && done) begin
      if (pending_quats.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("[%0t] result with no request outstanding: w=%0d x=%0d y=%0d z=%0d",
                   $realtime, quat_w, quat_x, quat_y, quat_z);
      end else begin
        want = pending_quats.pop_front();
        check_component("w", want.w, quat_w);
        check_component("x", want.x, quat_x);
        check_component("y", want.y, quat_y);
        check_component("z", want.z, quat_z);
        results_seen++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               pending_quats.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one request and hold it until the unit takes it.
  task automatic send_request(input logic [ANGLE_BITS-1:0] roll,
                              input logic [ANGLE_BITS-1:0] pitch,
                              input logic [ANGLE_BITS-1:0] yaw);
    start <= 1'b1;
    roll_angle <= roll;
    pitch_angle <= pitch;
    yaw_angle <= yaw;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_quats.push_back(predict_quaternion(roll, pitch, yaw));
    requests_sent++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Mostly back to back, sometimes a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Full-range angles, with some close to the quadrant boundaries.
  function automatic logic [ANGLE_BITS-1:0] random_angle();
    logic [ANGLE_BITS-1:0] base;
    if ($urandom_range(0, 3) != 0) return ANGLE_BITS'($urandom);
    base = ANGLE_BITS'($urandom_range(0, 3)) << (ANGLE_BITS - 2);
    return base + ANGLE_BITS'($urandom_range(0, 16)) - ANGLE_BITS'(8);
  endfunction

  // Stop sending and let every outstanding result arrive; with nothing
  // outstanding, start is already low and nothing is driven.
  task automatic wait_for_drain();
    if (pending_quats.size() != 0) begin
      start <= 1'b0;
      while (pending_quats.size() != 0) @(posedge clk);
    end
  endtask

  // Field extremes, half-turn fold boundary, quarter turns, and both saturations.
  task automatic test_directed_angles();
    logic [ANGLE_BITS-1:0] cases [][3];
    cases = '{
      '{16'h0000, 16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{16'h8000, 16'h0000, 16'h0000}, '{16'h0000, 16'h8000, 16'h0000},
      '{16'h0000, 16'h0000, 16'h8000}, '{16'h8001, 16'h8001, 16'h8001},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF}, '{16'h4000, 16'h4000, 16'h4000},
      '{16'hC000, 16'hC000, 16'hC000}, '{16'hFFFF, 16'h0000, 16'h0000},
      '{16'h0000, 16'hFFFF, 16'h0000}, '{16'h0000, 16'h0000, 16'hFFFF},
      '{16'h8000, 16'h8000, 16'h8000}, '{16'h4000, 16'h0000, 16'h0000},
      '{16'h0000, 16'h4000, 16'h0000}, '{16'h0000, 16'h0000, 16'h4000},
      '{16'hFFFF, 16'h8000, 16'h0001}, '{16'h0001, 16'h0001, 16'h0001},
      '{16'hAAAA, 16'h5555, 16'hAAAA}, '{16'h5555, 16'hAAAA, 16'h5555},
      '{16'hFFFF, 16'hFFFF, 16'h0000}
    };
    foreach (cases[i]) send_request(cases[i][0], cases[i][1], cases[i][2]);
    wait_for_drain();
  endtask

  // A long stretch at full rate with no gaps at all.
  task automatic test_full_rate();
    repeat (100) send_request(random_angle(), random_angle(), random_angle());
    wait_for_drain();
  endtask

  // Random requests with random gaps, pausing now and then for a full drain.
  task automatic test_random_gaps();
    for (int i = 0; i < 200; i++) begin
      send_request(random_angle(), random_angle(), random_angle());
      if ($urandom_range(0, 49) == 0) wait_for_drain();
      else idle_cycles(pick_gap());
    end
    wait_for_drain();
  endtask

  // Angles near zero, a quarter, a half and three quarters of a turn.
  task automatic test_quadrant_edges();
    logic [ANGLE_BITS-1:0] a [3];
    for (int i = 0; i < 100; i++) begin
      foreach (a[k])
        a[k] = (ANGLE_BITS'($urandom_range(0, 3)) << (ANGLE_BITS - 2))
               + ANGLE_BITS'($urandom_range(0, 6)) - ANGLE_BITS'(3);
      send_request(a[0], a[1], a[2]);
      idle_cycles(pick_gap());
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_angles();
    test_full_rate();
    test_random_gaps();
    test_quadrant_edges();

    // Allow for any stray strobe after the last expected one.
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (pending_quats.size() != 0) error_count += pending_quats.size();

    $display("Sent %0d angle triples (directed, full rate, gapped, near quadrant edges);",
             requests_sent);
    $display("checked %0d quaternions, %0d errors.", results_seen, error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/e2q_pkg.sv
src/e2q_cordic.sv
src/e2q_quat.sv
src/euler_to_quaternion_unit.sv
bench/tb_euler_to_quaternion_unit.sv
